@@ rtl/core/cci_pkg.sv @@
// Shared types and constants for the circle collision impulse core.
// No dependencies; imported by cci_geom, cci_axis and the top module.
package cci_pkg;

  localparam int MAG_W  = 32;   // magnitude of a coordinate or velocity difference
  localparam int DD_W   = 65;   // squared distance and dot product magnitude
  localparam int GAIN_W = 17;   // 1 + e in Q1.16
  localparam int MSUM_W = 32;   // sum of the two inverse masses

  localparam logic [15:0]       RESTITUTION_RESET = 16'd62259;
  localparam logic [GAIN_W-1:0] ONE_Q16           = 17'h10000;
  localparam logic [31:0]       SAT_POS           = 32'h7FFF_FFFF;
  localparam logic [31:0]       SAT_NEG           = 32'h8000_0000;

  // Geometry front end result for one body pair.
  typedef struct packed {
    logic [DD_W-1:0]   smag;   // |v.d|
    logic [DD_W-1:0]   dd;     // d.d
    logic [MAG_W-1:0]  adx;
    logic [MAG_W-1:0]  ady;
    logic              ndx;    // dx < 0
    logic              ndy;    // dy < 0
    logic              coll;   // circles overlap or touch
    logic              imp;    // overlapping, approaching, nonzero distance and mass sum
    logic [MSUM_W-1:0] msum;
    logic [GAIN_W-1:0] gain;
  } geom_t;

endpackage

@@ rtl/core/cci_geom.sv @@
// Front end: differences, magnitudes, squares, dot product and overlap test.
// Depends on cci_pkg.
module cci_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic [30:0]        radius_a,
  input  logic [30:0]        radius_b,
  input  logic [30:0]        inv_mass_a,
  input  logic [30:0]        inv_mass_b,
  input  logic [15:0]        restitution,
  output logic               out_valid,
  output cci_pkg::geom_t     out
);
  import cci_pkg::*;

  logic [4:0] v;

  // stage 1
  logic [32:0]       dx, dy, vx, vy;
  logic [31:0]       r1, ms1;
  logic [GAIN_W-1:0] gn1;
  // stage 2
  logic [MAG_W-1:0]  adx2, ady2, avx2, avy2, r2, ms2;
  logic              sdx2, sdy2, n1_2, n2_2;
  logic [GAIN_W-1:0] gn2;
  // stage 3
  logic [63:0]       sqx, sqy, p1, p2, rr3;
  logic [MAG_W-1:0]  adx3, ady3, ms3;
  logic              sdx3, sdy3, n1_3, n2_3;
  logic [GAIN_W-1:0] gn3;
  // stage 4
  logic [DD_W-1:0]   dd4, smag4;
  logic [63:0]       rr4;
  logic              sneg4, sdx4, sdy4;
  logic [MAG_W-1:0]  adx4, ady4, ms4;
  logic [GAIN_W-1:0] gn4;

  logic [DD_W-1:0]   psum;
  logic [63:0]       pdiff;
  logic              pge;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_comb begin
    psum  = {1'b0, p1} + {1'b0, p2};
    pge   = p1 >= p2;
    pdiff = pge ? (p1 - p2) : (p2 - p1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= {pos_a_x[31], pos_a_x} - {pos_b_x[31], pos_b_x};
      dy  <= {pos_a_y[31], pos_a_y} - {pos_b_y[31], pos_b_y};
      vx  <= {vel_a_x[31], vel_a_x} - {vel_b_x[31], vel_b_x};
      vy  <= {vel_a_y[31], vel_a_y} - {vel_b_y[31], vel_b_y};
      r1  <= {1'b0, radius_a} + {1'b0, radius_b};
      ms1 <= {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
      gn1 <= ONE_Q16 + {1'b0, restitution};

      adx2 <= dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
      ady2 <= dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
      avx2 <= vx[32] ? (~vx[31:0] + 32'd1) : vx[31:0];
      avy2 <= vy[32] ? (~vy[31:0] + 32'd1) : vy[31:0];
      sdx2 <= dx[32];
      sdy2 <= dy[32];
      n1_2 <= vx[32] ^ dx[32];
      n2_2 <= vy[32] ^ dy[32];
      r2   <= r1;
      ms2  <= ms1;
      gn2  <= gn1;

      sqx  <= adx2 * adx2;
      sqy  <= ady2 * ady2;
      p1   <= avx2 * adx2;
      p2   <= avy2 * ady2;
      rr3  <= r2 * r2;
      adx3 <= adx2;
      ady3 <= ady2;
      sdx3 <= sdx2;
      sdy3 <= sdy2;
      n1_3 <= n1_2;
      n2_3 <= n2_2;
      ms3  <= ms2;
      gn3  <= gn2;

      // signed dot product as sign and magnitude
      dd4 <= {1'b0, sqx} + {1'b0, sqy};
      if (n1_3 == n2_3) begin
        smag4 <= psum;
        sneg4 <= n1_3;
      end else begin
        smag4 <= {1'b0, pdiff};
        sneg4 <= pge ? n1_3 : n2_3;
      end
      rr4  <= rr3;
      adx4 <= adx3;
      ady4 <= ady3;
      sdx4 <= sdx3;
      sdy4 <= sdy3;
      ms4  <= ms3;
      gn4  <= gn3;

      out.smag <= smag4;
      out.dd   <= dd4;
      out.adx  <= adx4;
      out.ady  <= ady4;
      out.ndx  <= sdx4;
      out.ndy  <= sdy4;
      out.coll <= dd4 <= {1'b0, rr4};
      out.imp  <= (dd4 <= {1'b0, rr4}) && sneg4 && (smag4 != '0) && (ms4 != '0)
                  && (dd4 != '0);
      out.msum <= ms4;
      out.gain <= gn4;
    end
  end

  assign out_valid = v[4];

endmodule

@@ rtl/core/cci_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module cci_div #(
  parameter int NW = 97,
  parameter int DW = 65,
  parameter int QW = 33,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  logic [QW:0]   v;
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] lo  [QW+1];   // numerator bits still to enter; quotient shifts in below
  logic [DW-1:0] dn  [QW+1];
  logic          ov  [QW+1];
  logic [SW-1:0] sd  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num >> QW);
      lo[0]  <= num[QW-1:0];
      dn[0]  <= den;
      ov[0]  <= (num >> QW) >= NW'(den);
      sd[0]  <= side_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;

    assign t  = {rem[k], lo[k][QW-1]};
    assign ge = t >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DW'(t - {1'b0, dn[k]}) : t[DW-1:0];
        lo[k+1]  <= {lo[k][QW-2:0], ge};
        dn[k+1]  <= dn[k];
        ov[k+1]  <= ov[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = lo[QW];
  assign ovf       = ov[QW];
  assign side_out  = sd[QW];

endmodule

@@ rtl/core/cci_axis.sv @@
// One impulse axis: |s|*|d_k| / dd, times (1+e), over the mass sum, saturated.
// Depends on cci_pkg and cci_div.
module cci_axis #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [cci_pkg::DD_W-1:0]   smag,
  input  logic [cci_pkg::DD_W-1:0]   dd,
  input  logic [cci_pkg::MAG_W-1:0]  adk,
  input  logic                       ndk,
  input  logic [cci_pkg::MSUM_W-1:0] msum,
  input  logic [cci_pkg::GAIN_W-1:0] gain,
  input  logic [SW-1:0]              side_in,
  output logic                       out_valid,
  output logic [31:0]                imp_k,
  output logic [SW-1:0]              side_out
);
  import cci_pkg::*;

  localparam int Q1W  = 33;
  localparam int N1W  = DD_W + MAG_W;
  localparam int PW   = Q1W + GAIN_W;
  localparam int N2W  = PW + FRAC_BITS;
  localparam int D2W  = MSUM_W + 16;
  localparam int S1W  = SW + 1 + MSUM_W + GAIN_W;
  localparam int S2W  = SW + 2;

  // partial products of |s| * |d_k|
  logic              a1_v;
  logic [63:0]       pl;
  logic [64:0]       ph;
  logic [DD_W-1:0]   dd1;
  logic              ndk1;
  logic [MSUM_W-1:0] ms1;
  logic [GAIN_W-1:0] gn1;
  logic [SW-1:0]     sd1;

  logic              d1_v, d1_ovf;
  logic [Q1W-1:0]    q1;
  logic [S1W-1:0]    d1_side;

  logic              a3_v, ovf3, ndk3;
  logic [PW-1:0]     prod;
  logic [MSUM_W-1:0] ms3;
  logic [SW-1:0]     sd3;

  logic              d2_v, d2_ovf;
  logic [31:0]       q2;
  logic [S2W-1:0]    d2_side;
  logic              sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_v      <= 1'b0;
      a3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a1_v      <= in_valid;
      a3_v      <= d1_v;
      out_valid <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= smag[31:0] * adk;
      ph   <= smag[64:32] * adk;
      dd1  <= dd;
      ndk1 <= ndk;
      ms1  <= msum;
      gn1  <= gain;
      sd1  <= side_in;
    end
  end

  cci_div #(.NW(N1W), .DW(DD_W), .QW(Q1W), .SW(S1W)) u_div_q (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a1_v),
    .num      ({ph, 32'd0} + {33'd0, pl}),
    .den      (dd1),
    .side_in  ({sd1, ndk1, ms1, gn1}),
    .out_valid(d1_v),
    .quot     (q1),
    .ovf      (d1_ovf),
    .side_out (d1_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= q1 * d1_side[GAIN_W-1:0];
      ms3  <= d1_side[GAIN_W +: MSUM_W];
      ndk3 <= d1_side[GAIN_W+MSUM_W];
      sd3  <= d1_side[S1W-1 -: SW];
      ovf3 <= d1_ovf;
    end
  end

  cci_div #(.NW(N2W), .DW(D2W), .QW(32), .SW(S2W)) u_div_m (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a3_v),
    .num      (N2W'(prod) << FRAC_BITS),
    .den      ({ms3, 16'd0}),
    .side_in  ({sd3, ndk3, ovf3}),
    .out_valid(d2_v),
    .quot     (q2),
    .ovf      (d2_ovf),
    .side_out (d2_side)
  );

  assign sat = d2_ovf | d2_side[0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d2_side[1]) begin
        imp_k <= (sat || q2[31]) ? SAT_POS : q2;
      end else begin
        imp_k <= (sat || (q2 > SAT_NEG)) ? SAT_NEG : (32'd0 - q2);
      end
      side_out <= d2_side[S2W-1 -: SW];
    end
  end

endmodule

@@ rtl/core/circle_collision_impulse_core.sv @@
// Circle collision impulse core: throughput one item per cycle while the skid
// entry is empty; the two 33- and 32-stage bit-per-stage dividers per axis set
// the depth. An output register plus one skid entry decouple the result side, so
// input is taken while a result waits.
// Reset (synchronous, rst high) clears all valid bits and loads restitution 0.95.
// Depends on cci_pkg, cci_geom, cci_axis, cci_div.
module circle_collision_impulse_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic [30:0]        radius_a,
  input  logic [30:0]        radius_b,
  input  logic [30:0]        inv_mass_a,
  input  logic [30:0]        inv_mass_b,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               collided,
  output logic               impulse_valid,
  output logic signed [31:0] impulse_x,
  output logic signed [31:0] impulse_y,
  // restitution write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import cci_pkg::*;

  logic [15:0] restitution;
  logic        en;

  logic        g_v;
  geom_t       g;

  logic        xv, yv;
  logic [31:0] ix, iy;
  logic        coll_s, imp_s;

  // result as it leaves the pipeline
  logic        r_coll, r_ivalid;
  logic [31:0] r_ix, r_iy;

  logic        skid_valid;
  logic        skid_coll, skid_ivalid;
  logic [31:0] skid_ix, skid_iy;

  // Restitution register; the user must write it only while idle, so the pipeline
  // may sample it at entry. The block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTITUTION_RESET;
    end else if (cfg_valid) begin
      restitution <= cfg_data;
    end
  end

  // The whole pipeline advances together; freeze it only while the skid
  // entry holds an item, so nothing is dropped or duplicated.
  assign en       = !skid_valid;
  assign in_ready = en;

  cci_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .pos_a_x    (pos_a_x),
    .pos_a_y    (pos_a_y),
    .pos_b_x    (pos_b_x),
    .pos_b_y    (pos_b_y),
    .vel_a_x    (vel_a_x),
    .vel_a_y    (vel_a_y),
    .vel_b_x    (vel_b_x),
    .vel_b_y    (vel_b_y),
    .radius_a   (radius_a),
    .radius_b   (radius_b),
    .inv_mass_a (inv_mass_a),
    .inv_mass_b (inv_mass_b),
    .restitution(restitution),
    .out_valid  (g_v),
    .out        (g)
  );

  // x lane carries the overlap flag, y lane the impulse-enable flag.
  cci_axis #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g_v),
    .smag     (g.smag),
    .dd       (g.dd),
    .adk      (g.adx),
    .ndk      (g.ndx),
    .msum     (g.msum),
    .gain     (g.gain),
    .side_in  (g.coll),
    .out_valid(xv),
    .imp_k    (ix),
    .side_out (coll_s)
  );

  cci_axis #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g_v),
    .smag     (g.smag),
    .dd       (g.dd),
    .adk      (g.ady),
    .ndk      (g.ndy),
    .msum     (g.msum),
    .gain     (g.gain),
    .side_in  (g.imp),
    .out_valid(yv),
    .imp_k    (iy),
    .side_out (imp_s)
  );

  // Drop the impulse when the pair does not collide while approaching.
  always_comb begin
    r_coll   = coll_s;
    r_ix     = imp_s ? ix : 32'd0;
    r_iy     = imp_s ? iy : 32'd0;
    r_ivalid = imp_s && ((ix != 32'd0) || (iy != 32'd0));
  end

  // Output register and skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (xv) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        collided      <= skid_coll;
        impulse_valid <= skid_ivalid;
        impulse_x     <= skid_ix;
        impulse_y     <= skid_iy;
      end
    end else if (xv) begin
      if (out_valid && !out_ready) begin
        skid_coll   <= r_coll;
        skid_ivalid <= r_ivalid;
        skid_ix     <= r_ix;
        skid_iy     <= r_iy;
      end else begin
        collided      <= r_coll;
        impulse_valid <= r_ivalid;
        impulse_x     <= r_ix;
        impulse_y     <= r_iy;
      end
    end
  end

  // Both axis lanes must stay in lockstep.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) xv == yv)
    else $error("axis lanes out of step");

  // The skid entry fills only behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item with the output register empty");

  a_impulse_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && impulse_valid |-> collided)
    else $error("impulse reported without a collision");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !collided |-> impulse_x == 32'sd0 && impulse_y == 32'sd0)
    else $error("nonzero impulse on a miss");

endmodule
